[sv/acwr_pkg.sv]
// Shared types and codes for the ARP cache with request retry.
package acwr_pkg;

   typedef enum logic [2:0] {
      ACT_LOOKUP = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_QUEUE  = 3'd2,
      ACT_REMOVE = 3'd3,
      ACT_TICK   = 3'd4,
      ACT_CLEAR  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      KIND_REPLY     = 2'd0,
      KIND_RESEND    = 2'd1,
      KIND_DROPPED   = 2'd2,
      KIND_TICK_DONE = 2'd3
   } kind_type;

   localparam logic [1:0] CSR_ENTRY_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_MAX_SENDS     = 2'd1;
   localparam logic [1:0] CSR_RESEND_TICKS  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_C_SCAN,
      ST_C_WRITE,
      ST_R_SCAN,
      ST_R_WRITE,
      ST_T_CACHE,
      ST_T_REQ,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [7:0]  age;
   } cache_entry_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] ip;
      logic [1:0]  iface;
      logic [2:0]  sends;
      logic [7:0]  age;
   } req_entry_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } ring_ctrl_type;

endpackage

[sv/acwr_cache_cell.sv]
// One cache slot of the rotating cache ring.
module acwr_cache_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  acwr_pkg::ring_ctrl_type  ctrl,
   input  acwr_pkg::cache_entry_type d_in,
   output acwr_pkg::cache_entry_type q_out
);
   import acwr_pkg::*;

   logic            valid_ff;
   cache_entry_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= d_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         data_ff <= d_in;
      end
   end

   always_comb begin
      q_out       = data_ff;
      q_out.valid = valid_ff;
   end
endmodule

[sv/acwr_req_cell.sv]
// One pending-request slot of the rotating request ring.
module acwr_req_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  acwr_pkg::ring_ctrl_type ctrl,
   input  acwr_pkg::req_entry_type d_in,
   output acwr_pkg::req_entry_type q_out
);
   import acwr_pkg::*;

   logic          valid_ff;
   req_entry_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= d_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         data_ff <= d_in;
      end
   end

   always_comb begin
      q_out       = data_ff;
      q_out.valid = valid_ff;
   end
endmodule

[sv/arp_cache_with_request_retry.sv]
// ARP cache with aging and a pending-request table with retry.
//
// Request channel: start with req_action, req_ip_addr, req_mac_addr and
// req_iface_index; a request is taken when start is high and busy is low.
// Result channel: rsp_valid strobes one cycle per result with rsp_kind, rsp_hit,
// rsp_mac_out, rsp_ip_out, rsp_iface_out, rsp_table_full and rsp_last.
// The receiver cannot stall; every result shows for exactly one cycle.
// Config: csr_valid/csr_ready write channel, csr_index selects the register
// (0 entry timeout, 1 max sends, 2 resend interval), csr_data the value.
// Both tables are cell rings that rotate one slot per cycle in the scan, write
// and tick states; slot k heads its ring when the slot counter reads k, so one
// turn walks the table in slot order. Before its reply, lookup turns the cache;
// insert the requests, then the cache twice; queue the requests twice (not with
// a bad interface); remove the requests; tick the cache, then the requests;
// clear and other actions reply at once. A tick emits its resend/drop results
// during the request turn, one per cycle at most, then the tick-done result.
// busy stays high until the last result is registered. Reset empties both tables
// and loads the register defaults (timeout 30, max sends 5, resend interval 1).
module arp_cache_with_request_retry #(
   parameter int CACHE_ENTRIES   = 16,
   parameter int REQUEST_ENTRIES = 8,
   parameter int IFACE_COUNT     = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_ip_addr,
   input  logic [47:0] req_mac_addr,
   input  logic [1:0]  req_iface_index,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic        rsp_hit,
   output logic [47:0] rsp_mac_out,
   output logic [31:0] rsp_ip_out,
   output logic [1:0]  rsp_iface_out,
   output logic        rsp_table_full,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import acwr_pkg::*;

   localparam int MAXE = (CACHE_ENTRIES > REQUEST_ENTRIES) ? CACHE_ENTRIES : REQUEST_ENTRIES;
   localparam int CW   = $clog2(MAXE);
   localparam int CIW  = $clog2(CACHE_ENTRIES);
   localparam int RIW  = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;

   // configuration registers
   logic [7:0] timeout_ff;
   logic [2:0] max_sends_ff;
   logic [7:0] resend_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= 8'd30;
         max_sends_ff <= 3'd5;
         resend_ff    <= 8'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENTRY_TIMEOUT: timeout_ff   <= csr_data;
            CSR_MAX_SENDS:     max_sends_ff <= csr_data[2:0];
            CSR_RESEND_TICKS:  resend_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer state and latched request
   state_type   state_ff, state_in;
   action_type  op_ff;
   logic [31:0] op_ip_ff;
   logic [47:0] op_mac_ff;
   logic [1:0]  op_iface_ff;
   logic        iface_ok_ff;
   logic [CW-1:0] cnt_ff;

   // scan results
   logic           c_match_ff, c_free_ff, r_match_ff, r_free_ff;
   logic [CIW-1:0] c_match_idx_ff, c_free_idx_ff;
   logic [RIW-1:0] r_free_idx_ff;
   logic [47:0]    hit_mac_ff;

   // output registers
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic        rsp_hit_ff, rsp_full_ff, rsp_last_ff;
   logic [47:0] rsp_mac_ff;
   logic [31:0] rsp_ip_ff;
   logic [1:0]  rsp_iface_ff;

   logic accept, iface_ok_in, c_end, r_end;
   ring_ctrl_type c_ctrl, r_ctrl;

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign iface_ok_in = (32'(req_iface_index) < 32'(IFACE_COUNT));
   assign c_end       = (cnt_ff == CW'(CACHE_ENTRIES - 1));
   assign r_end       = (cnt_ff == CW'(REQUEST_ENTRIES - 1));

   // rings
   cache_entry_type c_q [CACHE_ENTRIES];
   cache_entry_type c_d [CACHE_ENTRIES];
   req_entry_type   r_q [REQUEST_ENTRIES];
   req_entry_type   r_d [REQUEST_ENTRIES];
   cache_entry_type c_tail;
   req_entry_type   r_tail;

   for (genvar gi = 0; gi < CACHE_ENTRIES; gi++) begin : g_cache
      if (gi == CACHE_ENTRIES - 1) begin : g_last
         assign c_d[gi] = c_tail;
      end else begin : g_mid
         assign c_d[gi] = c_q[gi+1];
      end
      acwr_cache_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (c_ctrl),
         .d_in  (c_d[gi]),
         .q_out (c_q[gi])
      );
   end

   for (genvar gj = 0; gj < REQUEST_ENTRIES; gj++) begin : g_req
      if (gj == REQUEST_ENTRIES - 1) begin : g_last
         assign r_d[gj] = r_tail;
      end else begin : g_mid
         assign r_d[gj] = r_q[gj+1];
      end
      acwr_req_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (r_ctrl),
         .d_in  (r_d[gj]),
         .q_out (r_q[gj])
      );
   end

   // head-of-ring processing
   cache_entry_type c_head;
   req_entry_type   r_head;
   logic            c_hit_head, r_hit_head;
   logic [8:0]      c_age_inc, r_age_inc;
   logic            r_due, r_drop;

   assign c_head     = c_q[0];
   assign r_head     = r_q[0];
   assign c_hit_head = c_head.valid && (c_head.ip == op_ip_ff);
   assign r_hit_head = r_head.valid && (r_head.ip == op_ip_ff);
   assign c_age_inc  = {1'b0, c_head.age} + 9'd1;
   assign r_age_inc  = {1'b0, r_head.age} + 9'd1;
   assign r_due      = r_head.valid && (r_age_inc > {1'b0, resend_ff});
   assign r_drop     = r_head.sends >= max_sends_ff;

   always_comb begin
      c_tail = c_head;
      unique case (state_ff)
         ST_C_WRITE: begin
            if (c_match_ff ? (cnt_ff[CIW-1:0] == c_match_idx_ff)
                           : (c_free_ff && cnt_ff[CIW-1:0] == c_free_idx_ff)) begin
               c_tail.valid = 1'b1;
               c_tail.ip    = op_ip_ff;
               c_tail.mac   = op_mac_ff;
               c_tail.age   = 8'd0;
            end
         end
         ST_T_CACHE: begin
            if (c_head.valid) begin
               c_tail.age = c_age_inc[8] ? 8'hFF : c_age_inc[7:0];
               if (c_age_inc > {1'b0, timeout_ff}) begin
                  c_tail.valid = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      r_tail = r_head;
      unique case (state_ff)
         ST_R_SCAN: begin
            // drop only the first matching request
            if (op_ff == ACT_REMOVE && r_hit_head && !r_match_ff) begin
               r_tail.valid = 1'b0;
            end
         end
         ST_R_WRITE: begin
            if (!r_match_ff && r_free_ff && cnt_ff[RIW-1:0] == r_free_idx_ff) begin
               r_tail.valid = 1'b1;
               r_tail.ip    = op_ip_ff;
               r_tail.iface = op_iface_ff;
               r_tail.sends = 3'd0;
               r_tail.age   = 8'd0;
            end
         end
         ST_T_REQ: begin
            if (r_head.valid) begin
               r_tail.age = r_age_inc[8] ? 8'hFF : r_age_inc[7:0];
               if (r_due) begin
                  if (r_drop) begin
                     r_tail.valid = 1'b0;
                  end else begin
                     r_tail.age   = 8'd0;
                     r_tail.sends = (r_head.sends == 3'd7) ? 3'd7 : r_head.sends + 3'd1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (req_action)
                  ACT_LOOKUP: state_in = ST_C_SCAN;
                  ACT_INSERT: state_in = ST_R_SCAN;
                  ACT_QUEUE:  state_in = iface_ok_in ? ST_R_SCAN : ST_REPLY;
                  ACT_REMOVE: state_in = ST_R_SCAN;
                  ACT_TICK:   state_in = ST_T_CACHE;
                  default:    state_in = ST_REPLY;
               endcase
            end
         end
         ST_C_SCAN: begin
            if (c_end) begin
               state_in = (op_ff == ACT_LOOKUP) ? ST_REPLY : ST_C_WRITE;
            end
         end
         ST_C_WRITE: if (c_end) state_in = ST_REPLY;
         ST_R_SCAN: begin
            if (r_end) begin
               priority case (op_ff)
                  ACT_INSERT: state_in = ST_C_SCAN;
                  ACT_QUEUE:  state_in = ST_R_WRITE;
                  default:    state_in = ST_REPLY;
               endcase
            end
         end
         ST_R_WRITE: if (r_end) state_in = ST_REPLY;
         ST_T_CACHE: if (c_end) state_in = ST_T_REQ;
         ST_T_REQ:   if (r_end) state_in = ST_REPLY;
         ST_REPLY:   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ring controls
   always_comb begin
      c_ctrl.shift = (state_ff == ST_C_SCAN) || (state_ff == ST_C_WRITE)
                  || (state_ff == ST_T_CACHE);
      r_ctrl.shift = (state_ff == ST_R_SCAN) || (state_ff == ST_R_WRITE)
                  || (state_ff == ST_T_REQ);
      c_ctrl.clear = accept && (req_action == ACT_CLEAR);
      r_ctrl.clear = accept && (req_action == ACT_CLEAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         // advance the slot counter while a ring turns, restart at each turn
         if ((c_ctrl.shift && c_end) || (r_ctrl.shift && r_end) || !(c_ctrl.shift || r_ctrl.shift))
            cnt_ff <= '0;
         else
            cnt_ff <= cnt_ff + CW'(1);
      end
   end

   // latch request and collect scan results
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= action_type'(req_action);
         op_ip_ff    <= req_ip_addr;
         op_mac_ff   <= req_mac_addr;
         op_iface_ff <= req_iface_index;
         iface_ok_ff <= iface_ok_in;
         c_match_ff  <= 1'b0;
         c_free_ff   <= 1'b0;
         r_match_ff  <= 1'b0;
         r_free_ff   <= 1'b0;
         hit_mac_ff  <= '0;
      end else if (state_ff == ST_C_SCAN) begin
         if (c_hit_head && !c_match_ff) begin
            c_match_ff     <= 1'b1;
            c_match_idx_ff <= cnt_ff[CIW-1:0];
            hit_mac_ff     <= c_head.mac;
         end
         if (!c_head.valid && !c_free_ff) begin
            c_free_ff     <= 1'b1;
            c_free_idx_ff <= cnt_ff[CIW-1:0];
         end
      end else if (state_ff == ST_R_SCAN) begin
         if (r_hit_head) r_match_ff <= 1'b1;
         if (!r_head.valid && !r_free_ff) begin
            r_free_ff     <= 1'b1;
            r_free_idx_ff <= cnt_ff[RIW-1:0];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_REPLY) || (state_ff == ST_T_REQ && r_due);
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= KIND_REPLY;
      rsp_hit_ff   <= 1'b0;
      rsp_mac_ff   <= '0;
      rsp_ip_ff    <= '0;
      rsp_iface_ff <= '0;
      rsp_full_ff  <= 1'b0;
      rsp_last_ff  <= 1'b0;
      if (state_ff == ST_T_REQ) begin
         rsp_kind_ff  <= r_drop ? KIND_DROPPED : KIND_RESEND;
         rsp_ip_ff    <= r_head.ip;
         rsp_iface_ff <= r_head.iface;
      end else if (state_ff == ST_REPLY) begin
         rsp_last_ff <= (op_ff <= ACT_CLEAR);
         priority case (op_ff)
            ACT_LOOKUP: begin
               rsp_hit_ff <= c_match_ff;
               rsp_mac_ff <= hit_mac_ff;
            end
            ACT_INSERT: begin
               rsp_hit_ff  <= r_match_ff;
               rsp_full_ff <= !c_match_ff && !c_free_ff;
            end
            ACT_QUEUE:  rsp_full_ff <= iface_ok_ff && !r_match_ff && !r_free_ff;
            ACT_TICK:   rsp_kind_ff <= KIND_TICK_DONE;
            default: ;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_mac_out    = rsp_mac_ff;
   assign rsp_ip_out     = rsp_ip_ff;
   assign rsp_iface_out  = rsp_iface_ff;
   assign rsp_table_full = rsp_full_ff;
   assign rsp_last       = rsp_last_ff;
endmodule
